>>> hw/rtl/hst_pkg.sv
package hst_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = 6;
    localparam int CNT_W    = 7;
    localparam int VAL_W    = 32;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SET = 2'd1;
    localparam logic [1:0] OP_TAS = 2'd2;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_FULL   = 2'd1;
    localparam logic [1:0] STATUS_IN_USE = 2'd2;
    localparam logic [1:0] STATUS_RANGE  = 2'd3;

    // write into one slot, as seen by the free-slot tracker
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] addr;
        logic             now_free;
    } track_update_t;

    typedef struct packed {
        logic [CNT_W-1:0] free_count;
        logic [CNT_W-1:0] first_free;
        logic             addr_free;
    } track_status_t;

endpackage

>>> hw/rtl/handle_slot_table.sv
// handle table with a fixed number of slots; a stored value of zero marks a free slot
// input channel s_axis_*: one operation per transaction, kind in tuser
//   add stores tdata's value in the lowest free slot, set writes the given slot,
//   test-and-set writes the given slot only when it is free
// output channel m_axis_*: one result per operation, status in tuser, and the
//   written index, free-slot count and lowest free index in tdata
// the slot memory is read on acceptance and written back from the ST_EXEC state
//   once the output register is free, which loads the result into that register
// no new operation is taken until the read-modify-write of the single-port slot
//   memory is done; s_axis_tready is low during the write-back cycle
// a finished result sits in the output register while the next operation is
//   accepted and read; if m_axis_tready stays low that operation waits in its
//   write-back cycle and no further input is taken
// reset clears the per-slot written flags and the free map at once, so every
//   slot reads as free and zero; the block is ready as soon as reset is released
module handle_slot_table
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // slot_index[5:0], entry_value[37:6], zero pad
    input  logic [1:0]  s_axis_tuser,   // operation[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // result_index[5:0], free_count[12:6],
                                        // first_free_index[19:13], zero pad
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    typedef enum logic [1:0]
    {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [hst_pkg::VAL_W-1:0] slot_mem [hst_pkg::CAPACITY];
    logic [hst_pkg::VAL_W-1:0] rdata_reg;
    logic [hst_pkg::CAPACITY-1:0] written_reg;

    logic [1:0]                op_reg;
    logic [hst_pkg::IDX_W-1:0] addr_reg;
    logic [hst_pkg::VAL_W-1:0] val_reg;
    logic                      range_err_reg;

    logic                      m_valid_reg;
    logic [1:0]                status_reg;
    logic [hst_pkg::IDX_W-1:0] res_idx_reg;

    logic                      s_accept;
    logic                      out_free;
    logic                      exec_go;
    logic [1:0]                in_op;
    logic [hst_pkg::IDX_W-1:0] in_idx;
    logic [hst_pkg::VAL_W-1:0] in_val;
    logic [hst_pkg::IDX_W-1:0] rd_addr;
    logic                      in_use;
    logic                      do_write;
    logic [1:0]                status_next;

    hst_pkg::track_update_t upd;
    hst_pkg::track_status_t stat;

    assign in_op  = s_axis_tuser;
    assign in_idx = s_axis_tdata[5:0];
    assign in_val = s_axis_tdata[37:6];

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_valid_reg || m_axis_tready;
    assign exec_go       = (state_reg == ST_EXEC) && out_free;

    // add goes to the lowest free slot, the others to the given index
    assign rd_addr = (in_op == hst_pkg::OP_ADD) ? stat.first_free[hst_pkg::IDX_W-1:0] : in_idx;

    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            slot_mem[addr_reg] <= val_reg;
        end
        if (s_accept)
        begin
            rdata_reg <= slot_mem[rd_addr];
        end
    end

    // a slot never written since reset counts as holding zero
    assign in_use = written_reg[addr_reg] && (rdata_reg != '0);

    always_comb
    begin
        status_next = hst_pkg::STATUS_OK;
        do_write    = 1'b0;
        case (op_reg)
            hst_pkg::OP_ADD:
            begin
                if (stat.free_count == '0)
                begin
                    status_next = hst_pkg::STATUS_FULL;
                end
                else
                begin
                    do_write = exec_go;
                end
            end
            hst_pkg::OP_SET:
            begin
                if (range_err_reg)
                begin
                    status_next = hst_pkg::STATUS_RANGE;
                end
                else
                begin
                    do_write = exec_go;
                end
            end
            hst_pkg::OP_TAS:
            begin
                if (range_err_reg)
                begin
                    status_next = hst_pkg::STATUS_RANGE;
                end
                else if (in_use)
                begin
                    status_next = hst_pkg::STATUS_IN_USE;
                end
                else
                begin
                    do_write = exec_go;
                end
            end
            default:
            begin
                status_next = hst_pkg::STATUS_OK;
            end
        endcase
    end

    assign upd.we       = do_write;
    assign upd.addr     = addr_reg;
    assign upd.now_free = (val_reg == '0);

    hst_free_tracker u_tracker
    (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (upd),
        .stat  (stat)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            written_reg <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (do_write)
            begin
                written_reg[addr_reg] <= 1'b1;
            end
            if (exec_go)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            op_reg        <= in_op;
            addr_reg      <= rd_addr;
            val_reg       <= in_val;
            range_err_reg <= ({1'b0, in_idx} >= hst_pkg::CNT_W'(hst_pkg::CAPACITY));
        end
        if (exec_go)
        begin
            status_reg  <= status_next;
            res_idx_reg <= (status_next == hst_pkg::STATUS_OK && do_write) ? addr_reg : '0;
        end
    end

    // count and lowest index come straight from the tracker: it only changes in the
    // cycle that loads a new result, so they stay matched to the result on display
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {4'b0000, stat.first_free, stat.free_count, res_idx_reg};

    a_occ_matches_mem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> (in_use == !stat.addr_free))
        else $error("slot memory contents disagree with free map");

    a_full_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        (stat.free_count == '0) == (stat.first_free == hst_pkg::CNT_W'(hst_pkg::CAPACITY)))
        else $error("free count and lowest free index disagree");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> (state_reg == ST_EXEC))
        else $error("accepted operation did not reach write-back");

    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> $past(state_reg == ST_EXEC))
        else $error("result appeared without a write-back cycle");

endmodule

>>> hw/rtl/hst_free_tracker.sv
module hst_free_tracker
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  hst_pkg::track_update_t upd,
    output hst_pkg::track_status_t stat
);

    logic [hst_pkg::CAPACITY-1:0] occ_reg;
    logic [hst_pkg::CAPACITY-1:0] occ_next;
    logic [hst_pkg::CNT_W-1:0]    count_reg;
    logic [hst_pkg::CNT_W-1:0]    count_next;
    logic [hst_pkg::CNT_W-1:0]    lowest_reg;
    logic [hst_pkg::CNT_W-1:0]    lowest_next;
    logic                         was_free;

    assign was_free = !occ_reg[upd.addr];

    always_comb
    begin
        occ_next   = occ_reg;
        count_next = count_reg;
        if (upd.we)
        begin
            occ_next[upd.addr] = !upd.now_free;
            if (was_free && !upd.now_free)
            begin
                count_next = count_reg - hst_pkg::CNT_W'(1);
            end
            else if (!was_free && upd.now_free)
            begin
                count_next = count_reg + hst_pkg::CNT_W'(1);
            end
        end
    end

    // priority encoder over the updated free map, capacity when none is free
    always_comb
    begin
        lowest_next = hst_pkg::CNT_W'(hst_pkg::CAPACITY);
        for (int i = hst_pkg::CAPACITY - 1; i >= 0; i--)
        begin
            if (!occ_next[i])
            begin
                lowest_next = hst_pkg::CNT_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg    <= '0;
            count_reg  <= hst_pkg::CNT_W'(hst_pkg::CAPACITY);
            lowest_reg <= '0;
        end
        else if (upd.we)
        begin
            occ_reg    <= occ_next;
            count_reg  <= count_next;
            lowest_reg <= lowest_next;
        end
    end

    assign stat.free_count = count_reg;
    assign stat.first_free = lowest_reg;
    assign stat.addr_free  = was_free;

endmodule
